@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every active clock edge.
`define GABG_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Consequent holds in the cycle where the antecedent holds.
`define GABG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent holds in the cycle after the antecedent.
`define GABG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/gabg_pkg.sv @@
// ----------------------------------------------------------------------------
// gabg_pkg
// Widths, register indexes and stage sideband types of the anchor generator.
// ----------------------------------------------------------------------------
package gabg_pkg;

    localparam int SIZE_W   = 11;
    localparam int SCALE_W  = 5;
    localparam int RATIO_W  = 5;
    localparam int STRIDE_W = 9;
    localparam int IDX_W    = 12;
    localparam int CFG_W    = 14;
    localparam int COORD_W  = 23;

    localparam int SIDE_W   = SIZE_W + SCALE_W;      // size * scale
    localparam int AREA_W   = 2 * SIDE_W;            // side squared
    localparam int DVD_W    = AREA_W - 2;            // area / 4
    localparam int XH_W     = AREA_W + RATIO_W - 2;  // area * ratio / 4
    localparam int ROOT_W   = (XH_W + 1) / 2;        // root bits per lane
    localparam int CTR_W    = 22;                    // (2*idx+1)*stride
    localparam int GRID_W   = 21;                    // (idx+1)*stride

    localparam logic [0:0] REG_INPUT_HEIGHT = 1'b0;
    localparam logic [0:0] REG_INPUT_WIDTH  = 1'b1;

    localparam logic [CFG_W-1:0] INPUT_SIZE_RST = CFG_W'(512);

    typedef struct packed {
        logic [XH_W-1:0]  xh;
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
        logic             in_grid;
    } div_side_t;

    typedef struct packed {
        logic [CTR_W-1:0] cx;
        logic [CTR_W-1:0] cy;
    } ctr_t;

endpackage

@@ design/gabg_front.sv @@
// ----------------------------------------------------------------------------
// gabg_front
// Three stages: side and cell products, area and grid test, divider and
// height radicand setup.
// ----------------------------------------------------------------------------
module gabg_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [gabg_pkg::SIZE_W-1:0]     anchor_size,
    input  logic [gabg_pkg::SCALE_W-1:0]    scale,
    input  logic [gabg_pkg::RATIO_W-1:0]    ratio,
    input  logic [gabg_pkg::STRIDE_W-1:0]   stride,
    input  logic [gabg_pkg::IDX_W-1:0]      row,
    input  logic [gabg_pkg::IDX_W-1:0]      col,
    input  logic [gabg_pkg::CFG_W-1:0]      input_height,
    input  logic [gabg_pkg::CFG_W-1:0]      input_width,
    output logic                            vld,
    output logic [gabg_pkg::DVD_W-1:0]      dvd,
    output logic [gabg_pkg::RATIO_W-1:0]    dvs,
    output gabg_pkg::div_side_t             side
);
    import gabg_pkg::*;

    logic                s0_vld_reg;
    logic [SIDE_W-1:0]   s0_side_reg;
    logic [RATIO_W-1:0]  s0_ratio_reg;
    logic [CTR_W-1:0]    s0_cx_reg;
    logic [CTR_W-1:0]    s0_cy_reg;
    logic [GRID_W-1:0]   s0_ph_reg;
    logic [GRID_W-1:0]   s0_pw_reg;
    logic                s0_snz_reg;

    logic                s1_vld_reg;
    logic [AREA_W-1:0]   s1_area_reg;
    logic [RATIO_W-1:0]  s1_ratio_reg;
    logic [CTR_W-1:0]    s1_cx_reg;
    logic [CTR_W-1:0]    s1_cy_reg;
    logic                s1_grid_reg;

    logic                s2_vld_reg;
    logic [DVD_W-1:0]    s2_dvd_reg;
    logic [RATIO_W-1:0]  s2_dvs_reg;
    div_side_t           s2_side_reg;

    logic [RATIO_W-1:0]          ratio_fix;
    logic [AREA_W+RATIO_W-1:0]   prod_hh;

    // a ratio of zero counts as one
    assign ratio_fix = (ratio == '0) ? RATIO_W'(1) : ratio;
    assign prod_hh   = (AREA_W+RATIO_W)'(s1_area_reg) * (AREA_W+RATIO_W)'(s1_ratio_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_vld_reg <= in_valid;
            s1_vld_reg <= s0_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_side_reg  <= SIDE_W'(anchor_size) * SIDE_W'(scale);
            s0_ratio_reg <= ratio_fix;
            s0_cx_reg    <= CTR_W'({col, 1'b1}) * CTR_W'(stride);
            s0_cy_reg    <= CTR_W'({row, 1'b1}) * CTR_W'(stride);
            s0_ph_reg    <= (GRID_W'(row) + GRID_W'(1)) * GRID_W'(stride);
            s0_pw_reg    <= (GRID_W'(col) + GRID_W'(1)) * GRID_W'(stride);
            s0_snz_reg   <= (stride != '0);

            s1_area_reg  <= AREA_W'(s0_side_reg) * AREA_W'(s0_side_reg);
            s1_ratio_reg <= s0_ratio_reg;
            s1_cx_reg    <= s0_cx_reg;
            s1_cy_reg    <= s0_cy_reg;
            // row < H/stride exactly when (row+1)*stride <= H
            s1_grid_reg  <= s0_snz_reg && (s0_ph_reg <= GRID_W'(input_height))
                                       && (s0_pw_reg <= GRID_W'(input_width));

            s2_dvd_reg         <= s1_area_reg[AREA_W-1:2];
            s2_dvs_reg         <= s1_ratio_reg;
            s2_side_reg.xh     <= prod_hh[AREA_W+RATIO_W-1:2];
            s2_side_reg.cx     <= s1_cx_reg;
            s2_side_reg.cy     <= s1_cy_reg;
            s2_side_reg.in_grid <= s1_grid_reg;
        end
    end

    assign vld  = s2_vld_reg;
    assign dvd  = s2_dvd_reg;
    assign dvs  = s2_dvs_reg;
    assign side = s2_side_reg;

endmodule

@@ design/gabg_div.sv @@
// ----------------------------------------------------------------------------
// gabg_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module gabg_div #(
    parameter int DW = 30,
    parameter int VW = 5,
    parameter int XW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_in,
    input  logic [DW-1:0] dvd,
    input  logic [VW-1:0] dvs,
    input  logic [XW-1:0] side_in,
    output logic          vld_out,
    output logic [DW-1:0] quo,
    output logic [XW-1:0] side_out
);
    logic          vld_reg  [DW];
    logic [DW-1:0] x_reg    [DW];
    logic [VW-1:0] rem_reg  [DW];
    logic [VW-1:0] dvs_reg  [DW];
    logic [XW-1:0] side_reg [DW];

    logic          vld_in_s  [DW];
    logic [DW-1:0] x_in_s    [DW];
    logic [VW-1:0] rem_in_s  [DW];
    logic [VW-1:0] dvs_in_s  [DW];
    logic [XW-1:0] side_in_s [DW];

    for (genvar i = 0; i < DW; i++)
    begin : g_stage
        logic [VW:0]   trial;
        logic          ge;
        logic [VW:0]   diff;

        if (i == 0)
        begin : g_first
            assign vld_in_s[i]  = vld_in;
            assign x_in_s[i]    = dvd;
            assign rem_in_s[i]  = '0;
            assign dvs_in_s[i]  = dvs;
            assign side_in_s[i] = side_in;
        end
        else
        begin : g_next
            assign vld_in_s[i]  = vld_reg[i-1];
            assign x_in_s[i]    = x_reg[i-1];
            assign rem_in_s[i]  = rem_reg[i-1];
            assign dvs_in_s[i]  = dvs_reg[i-1];
            assign side_in_s[i] = side_reg[i-1];
        end

        assign trial = {rem_in_s[i], x_in_s[i][DW-1]};
        assign ge    = (trial >= {1'b0, dvs_in_s[i]});
        assign diff  = ge ? (trial - {1'b0, dvs_in_s[i]}) : trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in_s[i];
            end
        end

        // shift the dividend out at the top, the quotient in at the bottom
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= {x_in_s[i][DW-2:0], ge};
                rem_reg[i]  <= diff[VW-1:0];
                dvs_reg[i]  <= dvs_in_s[i];
                side_reg[i] <= side_in_s[i];
            end
        end
    end

    assign vld_out  = vld_reg[DW-1];
    assign quo      = x_reg[DW-1];
    assign side_out = side_reg[DW-1];

endmodule

@@ design/gabg_sqrt.sv @@
// ----------------------------------------------------------------------------
// gabg_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module gabg_sqrt #(
    parameter int RW = 18,
    parameter int XW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vld_in,
    input  logic [2*RW-1:0] rad,
    input  logic [XW-1:0]   side_in,
    output logic            vld_out,
    output logic [RW-1:0]   root,
    output logic [XW-1:0]   side_out
);
    logic            vld_reg  [RW];
    logic [2*RW-1:0] x_reg    [RW];
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [XW-1:0]   side_reg [RW];

    logic            vld_in_s  [RW];
    logic [2*RW-1:0] x_in_s    [RW];
    logic [RW+1:0]   rem_in_s  [RW];
    logic [RW-1:0]   root_in_s [RW];
    logic [XW-1:0]   side_in_s [RW];

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [RW+3:0] acc;
        logic [RW+3:0] trial;
        logic          ge;
        logic [RW+3:0] diff;

        if (i == 0)
        begin : g_first
            assign vld_in_s[i]  = vld_in;
            assign x_in_s[i]    = rad;
            assign rem_in_s[i]  = '0;
            assign root_in_s[i] = '0;
            assign side_in_s[i] = side_in;
        end
        else
        begin : g_next
            assign vld_in_s[i]  = vld_reg[i-1];
            assign x_in_s[i]    = x_reg[i-1];
            assign rem_in_s[i]  = rem_reg[i-1];
            assign root_in_s[i] = root_reg[i-1];
            assign side_in_s[i] = side_reg[i-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign acc   = {rem_in_s[i], x_in_s[i][2*RW-1:2*RW-2]};
        assign trial = {2'b00, root_in_s[i], 2'b01};
        assign ge    = (acc >= trial);
        assign diff  = ge ? (acc - trial) : acc;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_in_s[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i]    <= {x_in_s[i][2*RW-3:0], 2'b00};
                rem_reg[i]  <= diff[RW+1:0];
                root_reg[i] <= {root_in_s[i][RW-2:0], ge};
                side_reg[i] <= side_in_s[i];
            end
        end
    end

    assign vld_out  = vld_reg[RW-1];
    assign root     = root_reg[RW-1];
    assign side_out = side_reg[RW-1];

endmodule

@@ design/gabg_back.sv @@
// ----------------------------------------------------------------------------
// gabg_back
// Output stage: box edges around the cell centre, saturated to 23 bits.
// ----------------------------------------------------------------------------
module gabg_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                vld,
    input  gabg_pkg::ctr_t                      ctr,
    input  logic [gabg_pkg::ROOT_W-1:0]         hw,
    input  logic [gabg_pkg::ROOT_W-1:0]         hh,
    input  logic                                grid,
    output logic                                out_valid,
    output logic signed [gabg_pkg::COORD_W-1:0] left_half,
    output logic signed [gabg_pkg::COORD_W-1:0] top_half,
    output logic signed [gabg_pkg::COORD_W-1:0] right_half,
    output logic signed [gabg_pkg::COORD_W-1:0] bottom_half,
    output logic                                in_grid
);
    import gabg_pkg::*;

    localparam int EW = CTR_W + 3;
    localparam logic signed [EW-1:0] C_MAX = EW'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [EW-1:0] C_MIN = -EW'(1 << (COORD_W - 1));

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [EW-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > C_MAX)
        begin
            r = C_MAX[COORD_W-1:0];
        end
        else if (v < C_MIN)
        begin
            r = C_MIN[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    logic                      vld_reg;
    logic signed [COORD_W-1:0] l_reg;
    logic signed [COORD_W-1:0] t_reg;
    logic signed [COORD_W-1:0] r_reg;
    logic signed [COORD_W-1:0] b_reg;
    logic                      g_reg;

    logic signed [EW-1:0] cx_e;
    logic signed [EW-1:0] cy_e;
    logic signed [EW-1:0] dw_e;
    logic signed [EW-1:0] dh_e;

    assign cx_e = $signed(EW'(ctr.cx));
    assign cy_e = $signed(EW'(ctr.cy));
    assign dw_e = $signed(EW'({hw, 1'b0}));
    assign dh_e = $signed(EW'({hh, 1'b0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_reg <= sat(cx_e - dw_e);
            t_reg <= sat(cy_e - dh_e);
            r_reg <= sat(cx_e + dw_e);
            b_reg <= sat(cy_e + dh_e);
            g_reg <= grid;
        end
    end

    assign out_valid   = vld_reg;
    assign left_half   = l_reg;
    assign top_half    = t_reg;
    assign right_half  = r_reg;
    assign bottom_half = b_reg;
    assign in_grid     = g_reg;

endmodule

@@ design/grid_anchor_box_generator_top.sv @@
// ----------------------------------------------------------------------------
// grid_anchor_box_generator_top
// One anchor box per query: half width and height from the scaled area and
// aspect ratio, centred on the grid cell, in half-pixel units.
// ----------------------------------------------------------------------------
// Fully pipelined: one query per cycle while in_ready is high. A query passes through
// 3 setup stages, 30 stages of the ratio divider, 18 stages of the two
// parallel square-root lanes and 1 output stage. The whole pipeline advances
// together whenever the output register is empty or being taken, so in_ready
// drops only while a result sits unaccepted at the output.
`include "assert_macros.svh"

module grid_anchor_box_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [0:0]                          cfg_index,
    input  logic [gabg_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gabg_pkg::SIZE_W-1:0]         anchor_size,
    input  logic [gabg_pkg::SCALE_W-1:0]        scale,
    input  logic [gabg_pkg::RATIO_W-1:0]        ratio,
    input  logic [gabg_pkg::STRIDE_W-1:0]       stride,
    input  logic [gabg_pkg::IDX_W-1:0]          row,
    input  logic [gabg_pkg::IDX_W-1:0]          col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gabg_pkg::COORD_W-1:0] left_half,
    output logic signed [gabg_pkg::COORD_W-1:0] top_half,
    output logic signed [gabg_pkg::COORD_W-1:0] right_half,
    output logic signed [gabg_pkg::COORD_W-1:0] bottom_half,
    output logic                                in_grid
);
    import gabg_pkg::*;

    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] width_reg;

    logic             en;
    logic             f_vld;
    logic [DVD_W-1:0] f_dvd;
    logic [RATIO_W-1:0] f_dvs;
    div_side_t        f_side;

    logic             d_vld;
    logic [DVD_W-1:0] d_quo;
    div_side_t        d_side;

    logic              hw_vld;
    logic [ROOT_W-1:0] hw_root;
    logic              hw_grid;
    logic              hh_vld;
    logic [ROOT_W-1:0] hh_root;
    ctr_t              hh_ctr;
    ctr_t              d_ctr;

    logic              box_ordered;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= INPUT_SIZE_RST;
            width_reg  <= INPUT_SIZE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_INPUT_HEIGHT: height_reg <= cfg_data;
                REG_INPUT_WIDTH:  width_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // advance everything unless the output holds an untaken result
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    gabg_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (in_valid),
        .anchor_size  (anchor_size),
        .scale        (scale),
        .ratio        (ratio),
        .stride       (stride),
        .row          (row),
        .col          (col),
        .input_height (height_reg),
        .input_width  (width_reg),
        .vld          (f_vld),
        .dvd          (f_dvd),
        .dvs          (f_dvs),
        .side         (f_side)
    );

    gabg_div #(
        .DW (DVD_W),
        .VW (RATIO_W),
        .XW ($bits(div_side_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (f_vld),
        .dvd      (f_dvd),
        .dvs      (f_dvs),
        .side_in  (f_side),
        .vld_out  (d_vld),
        .quo      (d_quo),
        .side_out (d_side)
    );

    assign d_ctr.cx = d_side.cx;
    assign d_ctr.cy = d_side.cy;

    gabg_sqrt #(
        .RW (ROOT_W),
        .XW (1)
    ) u_sqrt_hw (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (d_vld),
        .rad      ((2*ROOT_W)'(d_quo)),
        .side_in  (d_side.in_grid),
        .vld_out  (hw_vld),
        .root     (hw_root),
        .side_out (hw_grid)
    );

    gabg_sqrt #(
        .RW (ROOT_W),
        .XW ($bits(ctr_t))
    ) u_sqrt_hh (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (d_vld),
        .rad      ((2*ROOT_W)'(d_side.xh)),
        .side_in  (d_ctr),
        .vld_out  (hh_vld),
        .root     (hh_root),
        .side_out (hh_ctr)
    );

    gabg_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .vld         (hw_vld),
        .ctr         (hh_ctr),
        .hw          (hw_root),
        .hh          (hh_root),
        .grid        (hw_grid),
        .out_valid   (out_valid),
        .left_half   (left_half),
        .top_half    (top_half),
        .right_half  (right_half),
        .bottom_half (bottom_half),
        .in_grid     (in_grid)
    );

    assign box_ordered = (right_half >= left_half) && (bottom_half >= top_half);

    `GABG_ASSERT(a_lanes_aligned, clk, rst_n, hw_vld == hh_vld)
    `GABG_ASSERT_NEXT(a_stall_holds_lane, clk, rst_n, !en, $stable(hw_vld))
    `GABG_ASSERT_IMP(a_box_ordered, clk, rst_n, out_valid, box_ordered)

endmodule
